/* rtl/nic_pkg.sv */
// shared types, constants and codes for the nibble cpu core
package nic_pkg;

	localparam int MemBytes   = 1024;
	localparam int MemAw      = $clog2(MemBytes);
	localparam int StackDepth = 128;
	localparam int StackAw    = $clog2(StackDepth);
	localparam int StackCw    = $clog2(StackDepth + 1);
	localparam int RegCount   = 16;

	typedef struct packed {
		logic       cmd;
		logic [9:0] addr;
		logic [7:0] data;
	} nic_in_t;

	typedef struct packed {
		logic [9:0]         pc;
		logic               halted;
		logic [1:0]         event_res;
		logic [3:0]         reg_index;
		logic signed [31:0] reg_value;
		logic               last;
	} nic_out_t;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_DUMP  = 2'd1;
	localparam logic [1:0] EV_MEMRQ = 2'd2;
	localparam logic [1:0] EV_STACK = 2'd3;

	localparam logic [3:0] OP_HALT  = 4'd0;
	localparam logic [3:0] OP_ADD   = 4'd1;
	localparam logic [3:0] OP_AND   = 4'd2;
	localparam logic [3:0] OP_DIV   = 4'd3;
	localparam logic [3:0] OP_MUL   = 4'd4;
	localparam logic [3:0] OP_SUB   = 4'd5;
	localparam logic [3:0] OP_OR    = 4'd6;
	localparam logic [3:0] OP_STACK = 4'd7;
	localparam logic [3:0] OP_INT   = 4'd8;
	localparam logic [3:0] OP_ADDI  = 4'd9;
	localparam logic [3:0] OP_BEQ   = 4'd10;
	localparam logic [3:0] OP_BLT   = 4'd11;
	localparam logic [3:0] OP_JMP   = 4'd12;
	localparam logic [3:0] OP_CALL  = 4'd13;
	localparam logic [3:0] OP_LOAD  = 4'd14;
	localparam logic [3:0] OP_STORE = 4'd15;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FETCH, ST_DEC, ST_RDY, ST_EXEC, ST_DIV, ST_MEMRD, ST_MEMWB,
		ST_STKRD, ST_STKWB, ST_OUT, ST_DUMP
	} nic_state_t;

	// divider handshake
	typedef struct packed {
		logic start;
	} nic_div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} nic_div_sts_t;

endpackage

/* rtl/nibble_isa_cpu_core_top.sv */
// top level of the nibble cpu core: sequencer, memories, register file and output register
// A write item stores one byte. A step item fetches its four instruction bytes one per
// cycle from the single-port byte memory, then executes; loads and stores pass through
// ST_MEMRD and ST_MEMWB, stack ops through ST_STKRD and ST_STKWB, and divide waits in
// ST_DIV on the divider, which produces one quotient bit a cycle. Interrupt 0 delivers
// sixteen register dump items, one per cycle when not stalled. After reset the block
// sweeps the byte memory to zero before taking any item. One item is in work at a time;
// the next item is accepted while the previous result waits in the output register (after
// a dump, once its last item is taken), and its own result follows once that one is taken.
module nibble_isa_cpu_core_top import nic_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  nic_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output nic_out_t out_data
);

	logic [7:0]  mem [MemBytes];
	logic [31:0] stk [StackDepth];
	logic [31:0] regs_q [RegCount];

	nic_state_t state_q, state_d;
	logic [MemAw:0]   clr_q;
	logic             clr_busy;
	logic [MemAw-1:0] pc_q;
	logic             halt_q;
	logic [StackCw-1:0] sp_q;
	logic [1:0]       fcnt_q;
	logic [7:0]       b0_q, b1_q, b2_q, b3_q;
	logic [7:0]       mrd_q;
	logic [31:0]      srd_q;
	logic [31:0]      x_q, y_q;
	logic [1:0]       ev_q;
	logic [3:0]       didx_q;
	logic             ov_q;
	logic             ov_load;
	nic_out_t         od_q;

	// memory port
	logic             m_we;
	logic [MemAw-1:0] m_addr;
	logic [7:0]       m_wd;

	nic_div_ctl_t dctl;
	nic_div_sts_t dsts;
	logic [31:0]  quo;

	nic_divider u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .num(x_q), .den(y_q),
		.sts(dsts), .quo(quo)
	);

	assign clr_busy = !clr_q[MemAw];

	logic [3:0] op, ra, rb, dst;
	assign op  = b0_q[7:4];
	assign ra  = b0_q[3:0];
	assign rb  = b1_q[7:4];
	assign dst = b1_q[3:0];

	// effective load/store address, signed
	logic signed [33:0] ea;
	logic               ea_ok;
	assign ea    = {{2{y_q[31]}}, y_q} + 34'(signed'({1'b0, dst, 1'b0}));
	assign ea_ok = (ea >= 0) && (ea < 34'(MemBytes));

	// branch / jump targets
	logic signed [33:0] boff, btgt;
	logic [33:0]        jd;
	logic signed [33:0] jt;
	logic               btake;
	assign boff  = 34'(signed'({b1_q[3:0], b2_q, b3_q, 1'b0}));
	assign btgt  = 34'(signed'({1'b0, pc_q})) + boff;
	assign jd    = {5'd0, ra, b1_q, b2_q, b3_q, 1'b0};
	assign jt    = 34'(signed'({1'b0, pc_q})) + signed'(jd);
	assign btake = (op == OP_BEQ) ? (x_q == y_q) : ($signed(x_q) < $signed(y_q));

	logic [MemAw-1:0] pc2, pc4;
	assign pc2 = pc_q + MemAw'(2);
	assign pc4 = pc_q + MemAw'(4);

	logic [31:0] stop;
	assign stop = srd_q;

	always_comb begin
		m_we   = 1'b0;
		m_addr = pc_q + MemAw'(fcnt_q);
		m_wd   = in_data.data;
		if (clr_busy) begin
			m_we   = 1'b1;
			m_addr = clr_q[MemAw-1:0];
			m_wd   = '0;
		end else if (state_q == ST_IDLE && in_valid && !in_data.cmd) begin
			m_we   = 1'b1;
			m_addr = in_data.addr[MemAw-1:0];
		end else if (state_q == ST_MEMRD || state_q == ST_MEMWB) begin
			m_addr = ea[MemAw-1:0];
			m_we   = (state_q == ST_MEMWB) && op == OP_STORE && ea_ok;
			m_wd   = x_q[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (m_we) mem[m_addr] <= m_wd;
		mrd_q <= mem[m_addr];
	end

	logic [StackAw-1:0] s_raddr;
	assign s_raddr = StackAw'(sp_q - StackCw'(1));
	always_ff @(posedge clk) begin
		srd_q <= stk[s_raddr];
		if (state_q == ST_EXEC && sp_q < StackCw'(StackDepth) &&
		    ((op == OP_STACK && b1_q == 8'h01) || op == OP_CALL)) begin
			stk[sp_q[StackAw-1:0]] <= (op == OP_CALL) ? 32'(pc_q) + 32'd4 : x_q;
		end
	end

	assign in_stall = clr_busy || state_q != ST_IDLE;
	assign dctl.start = (state_q == ST_EXEC) && op == OP_DIV;

	// output register loads a new result item
	assign ov_load = (state_q == ST_OUT && (!ov_q || !out_stall)) ||
	                 (state_q == ST_DUMP && ov_q && !out_stall && !od_q.last);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (!clr_busy && in_valid) begin
				if (!in_data.cmd || halt_q) state_d = ST_OUT;
				else state_d = ST_FETCH;
			end
			ST_FETCH: if (fcnt_q == 2'd3) state_d = ST_DEC;
			ST_DEC:   state_d = ST_RDY;
			ST_RDY:   state_d = ST_EXEC;
			ST_EXEC: begin
				case (op)
					OP_DIV:   state_d = ST_DIV;
					OP_LOAD, OP_STORE: state_d = ST_MEMRD;
					OP_STACK: state_d = ST_STKRD;
					default:  state_d = ST_OUT;
				endcase
			end
			ST_DIV:   if (dsts.done) state_d = ST_OUT;
			ST_MEMRD: state_d = ST_MEMWB;
			ST_MEMWB: state_d = ST_OUT;
			ST_STKRD: state_d = ST_STKWB;
			ST_STKWB: state_d = ST_OUT;
			ST_OUT:   state_d = (ev_q == EV_DUMP) ? ST_DUMP : ST_IDLE;
			ST_DUMP:  if (ov_q && !out_stall && od_q.last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
		if (state_q == ST_OUT && ov_q && out_stall) state_d = ST_OUT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q   <= '0;
			pc_q    <= '0;
			halt_q  <= 1'b0;
			sp_q    <= '0;
			fcnt_q  <= '0;
			ov_q    <= 1'b0;
			ev_q    <= EV_NONE;
			didx_q  <= '0;
			od_q    <= '0;
			for (int i = 0; i < RegCount; i++) regs_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (clr_busy) clr_q <= clr_q + 1'b1;
			if (ov_load) ov_q <= 1'b1;
			else if (ov_q && !out_stall) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					fcnt_q <= '0;
					ev_q   <= EV_NONE;
				end
				ST_FETCH: fcnt_q <= fcnt_q + 2'd1;
				ST_DEC: ;
				ST_RDY: ;
				ST_EXEC: begin
					case (op)
						OP_HALT: halt_q <= 1'b1;
						OP_ADD: begin regs_q[dst] <= x_q + y_q; pc_q <= pc2; end
						OP_AND: begin regs_q[dst] <= x_q & y_q; pc_q <= pc2; end
						OP_SUB: begin regs_q[dst] <= x_q - y_q; pc_q <= pc2; end
						OP_OR:  begin regs_q[dst] <= x_q | y_q; pc_q <= pc2; end
						OP_MUL: begin regs_q[dst] <= x_q * y_q; pc_q <= pc2; end
						OP_DIV: pc_q <= pc2;
						OP_ADDI: begin regs_q[ra] <= x_q + 32'(b1_q); pc_q <= pc2; end
						OP_INT: begin
							if (b1_q == 8'd0) ev_q <= EV_DUMP;
							else if (b1_q == 8'd1) ev_q <= EV_MEMRQ;
							pc_q <= pc2;
						end
						OP_BEQ, OP_BLT: begin
							if (btake && btgt >= 0 && btgt < 34'(MemBytes))
								pc_q <= btgt[MemAw-1:0];
							else pc_q <= pc4;
						end
						OP_JMP: begin
							if (jd < 34'(MemBytes) && jt >= 0 && jt < 34'(MemBytes))
								pc_q <= jt[MemAw-1:0];
						end
						OP_CALL: begin
							if (sp_q >= StackCw'(StackDepth)) ev_q <= EV_STACK;
							else sp_q <= sp_q + StackCw'(1);
							pc_q <= (jd < 34'(MemBytes)) ? jd[MemAw-1:0] : '0;
						end
						OP_STACK: begin
							if (b1_q == 8'h10) begin
								if (sp_q == '0) ev_q <= EV_STACK;
								pc_q <= pc2;
							end else if (b1_q == 8'h01) begin
								if (sp_q >= StackCw'(StackDepth)) ev_q <= EV_STACK;
								else sp_q <= sp_q + StackCw'(1);
								pc_q <= pc2;
							end
						end
						default: pc_q <= pc2;
					endcase
				end
				ST_DIV: if (dsts.done) regs_q[dst] <= quo;
				ST_MEMWB: if (op == OP_LOAD && ea_ok) regs_q[ra] <= 32'(mrd_q);
				ST_STKRD: ;
				ST_STKWB: begin
					if (b1_q == 8'h10) begin
						if (sp_q != '0) begin
							regs_q[0] <= stop;
							sp_q      <= sp_q - StackCw'(1);
						end
					end else if (b1_q != 8'h01) begin
						if (sp_q == '0) begin
							ev_q <= EV_STACK;
							pc_q <= '0;
						end else if (!stop[31] && stop < 32'(MemBytes)) pc_q <= stop[MemAw-1:0];
						else pc_q <= '0;
					end
				end
				ST_OUT: if (ov_load) begin
					od_q.pc        <= 10'(pc_q);
					od_q.halted    <= halt_q;
					od_q.event_res <= ev_q;
					od_q.reg_index <= '0;
					od_q.reg_value <= (ev_q == EV_DUMP) ? regs_q[0] : '0;
					od_q.last      <= (ev_q != EV_DUMP);
					didx_q        <= 4'd1;
				end
				ST_DUMP: if (ov_load) begin
					od_q.reg_index <= didx_q;
					od_q.reg_value <= regs_q[didx_q];
					od_q.last      <= (didx_q == 4'(RegCount - 1));
					didx_q         <= didx_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	// operand and instruction byte capture
	always_ff @(posedge clk) begin
		if (state_q == ST_FETCH || state_q == ST_DEC) begin
			b0_q <= b1_q;
			b1_q <= b2_q;
			b2_q <= b3_q;
			b3_q <= mrd_q;
		end
		if (state_q == ST_RDY) begin
			x_q <= regs_q[ra];
			y_q <= regs_q[rb];
		end
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;

	a_dump_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> ov_q) else $error("no result held during dump");
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= StackCw'(StackDepth)) else $error("stack count overran depth");
	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		dsts.busy |-> state_q == ST_DIV) else $error("divider busy outside divide");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP && ov_q && !out_stall && od_q.last) |=> (state_q == ST_IDLE))
		else $error("dump not finished after last result");

endmodule

/* rtl/nic_divider.sv */
// iterative signed 32-bit divider, one quotient bit per cycle
module nic_divider import nic_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  nic_div_ctl_t ctl,
	input  logic [31:0]  num,
	input  logic [31:0]  den,
	output nic_div_sts_t sts,
	output logic [31:0]  quo
);

	logic [31:0] rem_q, q_q, d_q;
	logic [5:0]  cnt_q;
	logic        neg_q, zero_q, busy_q, done_q;
	logic [32:0] trial;
	logic [31:0] rem_sh;

	assign rem_sh = {rem_q[30:0], q_q[31]};
	assign trial  = {1'b0, rem_sh} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= '0;
			q_q    <= num[31] ? (~num + 32'd1) : num;
			d_q    <= den[31] ? (~den + 32'd1) : den;
			neg_q  <= num[31] ^ den[31];
			zero_q <= (den == 32'd0);
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				q_q   <= {q_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[30:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (zero_q) quo = '0;
		else if (neg_q) quo = ~q_q + 32'd1;
		else quo = q_q;
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

/* test/nibble_isa_cpu_core_top_test.sv */
// testbench for the nibble cpu core: programs written into memory, stepped and checked
`timescale 1ns / 100ps
module nibble_isa_cpu_core_top_test;
	import nic_pkg::*;

	localparam logic [7:0] STK_POP   = 8'h10;
	localparam logic [7:0] STK_PUSH  = 8'h01;
	localparam logic [7:0] STK_RET   = 8'h00;
	localparam logic [7:0] INT_DUMP  = 8'h00;
	localparam logic [7:0] INT_MEMRQ = 8'h01;
	localparam logic       CMD_WRITE = 1'b0;
	localparam logic       CMD_STEP  = 1'b1;
	localparam int         LIMIT     = 600000;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	nic_in_t  in_data;
	logic     out_valid;
	logic     out_stall;
	nic_out_t out_data;

	nibble_isa_cpu_core_top dut (.*);

	// shadow of the core state
	logic [7:0]  m_mem [MemBytes];
	logic [31:0] m_regs [RegCount];
	logic [31:0] m_stk [StackDepth];
	int          m_depth;
	int          m_pc;
	logic        m_halted;

	nic_in_t  pending[$];
	nic_out_t expected_res[$];
	int       n_queued, n_taken, fails, cycles;
	int       in_gap, out_gap;
	bit       calm, took;

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = 1'b1;
			#5 clk = 1'b0;
		end
	end

	function automatic bit in_mem(longint a);
		return a >= 0 && a < MemBytes;
	endfunction

	task automatic emit(logic [1:0] ev, logic [3:0] idx, logic [31:0] val, logic lst);
		nic_out_t r;
		r.pc = m_pc[9:0];
		r.halted = m_halted;
		r.event_res = ev;
		r.reg_index = idx;
		r.reg_value = val;
		r.last = lst;
		expected_res.push_back(r);
	endtask

	task automatic execute_item(nic_in_t it);
		logic [7:0]  b0, b1, b2, b3;
		logic [3:0]  op, ra, dst;
		logic [31:0] x, y;
		logic [27:0] far;
		logic [19:0] raw;
		logic [1:0]  ev;
		longint      t, d, off, n, dv;
		bit          take;
		if (it.cmd == CMD_WRITE) begin
			m_mem[it.addr] = it.data;
			emit(EV_NONE, 4'd0, 32'd0, 1'b1);
			return;
		end
		if (m_halted) begin
			emit(EV_NONE, 4'd0, 32'd0, 1'b1);
			return;
		end
		b0 = m_mem[m_pc % MemBytes];
		b1 = m_mem[(m_pc + 1) % MemBytes];
		b2 = m_mem[(m_pc + 2) % MemBytes];
		b3 = m_mem[(m_pc + 3) % MemBytes];
		op = b0[7:4];
		ra = b0[3:0];
		dst = b1[3:0];
		x = m_regs[ra];
		y = m_regs[b1[7:4]];
		far = {ra, b1, b2, b3};
		ev = EV_NONE;
		case (op)
			OP_HALT: m_halted = 1'b1;
			OP_ADD: begin m_regs[dst] = x + y; m_pc = (m_pc + 2) % MemBytes; end
			OP_AND: begin m_regs[dst] = x & y; m_pc = (m_pc + 2) % MemBytes; end
			OP_OR: begin m_regs[dst] = x | y; m_pc = (m_pc + 2) % MemBytes; end
			OP_SUB: begin m_regs[dst] = x - y; m_pc = (m_pc + 2) % MemBytes; end
			OP_MUL: begin m_regs[dst] = x * y; m_pc = (m_pc + 2) % MemBytes; end
			OP_DIV: begin
				n = longint'(signed'(x));
				dv = longint'(signed'(y));
				m_regs[dst] = (dv == 0) ? 32'd0 : 32'(n / dv);
				m_pc = (m_pc + 2) % MemBytes;
			end
			OP_STACK: begin
				if (b1 == STK_POP) begin
					if (m_depth == 0) ev = EV_STACK;
					else begin
						m_depth--;
						m_regs[0] = m_stk[m_depth];
					end
					m_pc = (m_pc + 2) % MemBytes;
				end else if (b1 == STK_PUSH) begin
					if (m_depth >= StackDepth) ev = EV_STACK;
					else begin
						m_stk[m_depth] = x;
						m_depth++;
					end
					m_pc = (m_pc + 2) % MemBytes;
				end else if (m_depth == 0) begin
					ev = EV_STACK;
					m_pc = 0;
				end else begin
					// return peeks at the top entry
					t = longint'(signed'(m_stk[m_depth - 1]));
					m_pc = in_mem(t) ? int'(t) : 0;
				end
			end
			OP_INT: begin
				if (b1 == INT_DUMP) ev = EV_DUMP;
				else if (b1 == INT_MEMRQ) ev = EV_MEMRQ;
				m_pc = (m_pc + 2) % MemBytes;
			end
			OP_ADDI: begin m_regs[ra] = x + b1; m_pc = (m_pc + 2) % MemBytes; end
			OP_BEQ, OP_BLT: begin
				take = (op == OP_BEQ) ? (x == y) : (signed'(x) < signed'(y));
				raw = {b1[3:0], b2, b3};
				off = raw[19] ? longint'(raw) - (longint'(1) << 20) : longint'(raw);
				t = m_pc + 2 * off;
				if (take && in_mem(t)) m_pc = int'(t);
				else m_pc = (m_pc + 4) % MemBytes;
			end
			OP_JMP: begin
				d = 2 * longint'(far);
				t = m_pc + d;
				if (in_mem(d) && in_mem(t)) m_pc = int'(t);
			end
			OP_CALL: begin
				d = 2 * longint'(far);
				if (m_depth >= StackDepth) ev = EV_STACK;
				else begin
					m_stk[m_depth] = m_pc + 4;
					m_depth++;
				end
				m_pc = in_mem(d) ? int'(d) : 0;
			end
			OP_LOAD: begin
				t = longint'(signed'(y)) + 2 * dst;
				if (in_mem(t)) m_regs[ra] = m_mem[t];
				m_pc = (m_pc + 2) % MemBytes;
			end
			default: begin
				t = longint'(signed'(y)) + 2 * dst;
				if (in_mem(t)) m_mem[t] = x[7:0];
				m_pc = (m_pc + 2) % MemBytes;
			end
		endcase
		if (ev == EV_DUMP) begin
			for (int k = 0; k < RegCount; k++)
				emit(EV_DUMP, k[3:0], m_regs[k], k == RegCount - 1);
		end else begin
			emit(ev, 4'd0, 32'd0, 1'b1);
		end
	endtask

	// driver: presents items at the falling edge
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took)) begin
			took = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending.size() > 0) begin
				in_data <= pending.pop_front();
				in_valid <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 9);
			end else begin
				in_valid <= 1'b0;
			end
		end
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (!calm && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 9);
		end
	end

	// monitor: accepted items feed the predictor, results are checked
	always @(posedge clk) begin
		nic_out_t e;
		cycles++;
		if (in_valid && !in_stall) begin
			execute_item(in_data);
			n_taken++;
			took = 1'b1;
		end
		if (out_valid && !out_stall) begin
			if (expected_res.size() == 0) begin
				$error("result with nothing expected: %p", out_data);
				fails++;
			end else begin
				e = expected_res.pop_front();
				if (out_data.pc !== e.pc) begin
					$error("pc: expected %0d, got %0d", e.pc, out_data.pc);
					fails++;
				end
				if (out_data.halted !== e.halted) begin
					$error("halted: expected %0d, got %0d", e.halted, out_data.halted);
					fails++;
				end
				if (out_data.event_res !== e.event_res) begin
					$error("event_res: expected %0d, got %0d", e.event_res, out_data.event_res);
					fails++;
				end
				if (out_data.reg_index !== e.reg_index) begin
					$error("reg_index: expected %0d, got %0d", e.reg_index, out_data.reg_index);
					fails++;
				end
				if (out_data.reg_value !== e.reg_value) begin
					$error("reg_value: expected %0d, got %0d", e.reg_value, out_data.reg_value);
					fails++;
				end
				if (out_data.last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, out_data.last);
					fails++;
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("nibble_isa_cpu_core_top_test NOT OK");
			$finish;
		end
	end

	task automatic put_item(logic c, int a, int dat);
		nic_in_t it;
		it.cmd = c;
		it.addr = a[9:0];
		it.data = dat[7:0];
		pending.push_back(it);
		n_queued++;
	endtask

	// wait until the predictor has seen every queued item
	task automatic sync_up();
		while (n_taken != n_queued) begin
			@(posedge clk);
			#1;
		end
	endtask

	// short instructions only need their first two bytes written
	task automatic run_insn(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, logic [7:0] b3);
		sync_up();
		put_item(CMD_WRITE, m_pc, b0);
		put_item(CMD_WRITE, m_pc + 1, b1);
		if (b0[7:4] inside {OP_BEQ, OP_BLT, OP_JMP, OP_CALL}) begin
			put_item(CMD_WRITE, m_pc + 2, b2);
			put_item(CMD_WRITE, m_pc + 3, b3);
		end
		put_item(CMD_STEP, $urandom_range(0, 1023), $urandom_range(0, 255));
	endtask

	task automatic random_insn();
		logic [3:0] op, ra;
		logic [7:0] b1, b2, b3;
		op = 4'($urandom_range(1, 15));
		ra = 4'($urandom);
		b1 = 8'($urandom);
		b2 = 8'($urandom);
		b3 = 8'($urandom);
		case (op)
			OP_STACK: if ($urandom_range(0, 3) != 0) b1 = $urandom_range(0, 1) ? STK_POP : STK_PUSH;
			OP_INT: if ($urandom_range(0, 2) != 0) b1 = $urandom_range(0, 1) ? INT_DUMP : INT_MEMRQ;
			OP_BEQ, OP_BLT: if ($urandom_range(0, 3) != 0) begin
				// short offset, forward or backward
				b2 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				b1[3:0] = {4{b2[0]}};
			end
			OP_JMP, OP_CALL: if ($urandom_range(0, 3) != 0) begin
				ra = '0;
				b1 = '0;
				b2 = 8'($urandom_range(0, 1));
			end
			default: ;
		endcase
		run_insn({op, ra}, b1, b2, b3);
	endtask

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		arst_n = 1'b0;
		for (int i = 0; i < MemBytes; i++) m_mem[i] = 0;
		for (int i = 0; i < RegCount; i++) m_regs[i] = 0;
		m_depth = 0;
		m_pc = 0;
		m_halted = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: build extreme values, every opcode but add, and, or and halt, corner cases
		run_insn({OP_ADDI, 4'd1}, 8'hFF, 0, 0);
		run_insn({OP_ADDI, 4'd1}, 8'h01, 0, 0);
		run_insn({OP_MUL, 4'd1}, 8'h12, 0, 0);
		run_insn({OP_ADDI, 4'd3}, 8'h80, 0, 0);
		run_insn({OP_MUL, 4'd3}, 8'h14, 0, 0);
		run_insn({OP_MUL, 4'd4}, 8'h25, 0, 0);
		run_insn({OP_ADDI, 4'd7}, 8'h01, 0, 0);
		run_insn({OP_SUB, 4'd0}, 8'h76, 0, 0);
		run_insn({OP_DIV, 4'd5}, 8'h68, 0, 0);
		run_insn({OP_DIV, 4'd1}, 8'h09, 0, 0);
		run_insn({OP_STACK, 4'd15}, STK_PUSH, 0, 0);
		run_insn({OP_STACK, 4'd0}, STK_POP, 0, 0);
		run_insn({OP_STACK, 4'd0}, STK_POP, 0, 0);
		run_insn({OP_STACK, 4'd0}, STK_RET, 0, 0);
		run_insn({OP_INT, 4'd0}, INT_DUMP, 0, 0);
		run_insn({OP_INT, 4'd0}, INT_MEMRQ, 0, 0);
		run_insn({OP_BEQ, 4'd0}, 8'h0F, 8'hFF, 8'hFE);
		run_insn({OP_BLT, 4'd6}, 8'h00, 8'h00, 8'h08);
		run_insn({OP_JMP, 4'd15}, 8'hFF, 8'hFF, 8'hFF);
		run_insn({OP_CALL, 4'd0}, 8'h00, 8'h00, 8'h40);
		run_insn({OP_STACK, 4'd0}, STK_RET, 0, 0);
		run_insn({OP_LOAD, 4'd1}, 8'h00, 0, 0);
		run_insn({OP_STORE, 4'd1}, 8'h03, 0, 0);
		run_insn({OP_CALL, 4'd15}, 8'hFF, 8'hFF, 8'hFF);

		// random programs, with stray writes and bare steps mixed in
		for (int i = 0; i < 6; i++) begin
			if (i == 3) calm = 1'b1;
			case ($urandom_range(0, 7))
				0: put_item(CMD_WRITE, $urandom_range(0, 1023), $urandom_range(0, 255));
				1: put_item(CMD_STEP, $urandom_range(0, 1023), $urandom_range(0, 255));
				default: random_insn();
			endcase
		end

		run_insn({OP_HALT, 4'd0}, 0, 0, 0);
		put_item(CMD_STEP, 1023, 255);
		put_item(CMD_WRITE, 1023, 255);
		put_item(CMD_STEP, 0, 0);

		sync_up();
		while (expected_res.size() > 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fails == 0 && expected_res.size() == 0) begin
			$display("nibble_isa_cpu_core_top_test OK");
		end else begin
			$display("nibble_isa_cpu_core_top_test NOT OK");
		end
		$finish;
	end

endmodule
